@@ hw/rtl/thp_sensor_compensation_assert.svh @@
// Assertion macros used by the checker file.
`ifndef THP_SENSOR_COMPENSATION_ASSERT_SVH
`define THP_SENSOR_COMPENSATION_ASSERT_SVH
// Antecedent implies consequent in the same cycle.
`define THP_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define THP_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ hw/rtl/thp_pkg.sv @@
`timescale 1ns / 1ps
package thp_pkg;
    localparam int unsigned QDEPTH = 4;
    localparam logic [2:0] REG_TEMP = 3'd0;
    localparam logic [2:0] REG_PA = 3'd1;
    localparam logic [2:0] REG_PB = 3'd2;
    localparam logic [2:0] REG_PC = 3'd3;
    localparam logic [2:0] REG_HUM = 3'd4;

    // One raw reading.
    typedef struct packed {
        logic [15:0] adc_humidity;
        logic [19:0] adc_pressure;
        logic [19:0] adc_temp;
    } raw_t;

    // One compensated result.
    typedef struct packed {
        logic        pressure_invalid;
        logic [16:0] humidity_q22_10;
        logic [31:0] pressure_q24_8;
        logic [31:0] temp_centi;
    } res_t;

    // Calibration registers.
    typedef struct packed {
        logic [47:0] cal_temp;
        logic [63:0] cal_press_a;
        logic [63:0] cal_press_b;
        logic [15:0] cal_press_c;
        logic [63:0] cal_hum;
    } cal_t;
endpackage

@@ hw/rtl/thp_sensor_compensation.sv @@
`timescale 1ns / 1ps
// Integer temperature, pressure and humidity compensation. One raw reading
// is accepted per cycle while the input queue is not full, and results leave
// in order. Most of the pipeline is the 64-stage pipelined pressure divider,
// and a full-rate stream is sustained as long as the output is taken each
// cycle. A four-entry input queue lets the input side keep running while the
// output stalls briefly. Calibration registers sit 8 bytes apart; the user
// must write them only while no reading is in flight, which the block itself
// does not enforce.
module thp_sensor_compensation
    import thp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // adc_temp [19:0], adc_pressure [39:20], adc_humidity [55:40]
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // temp_centi [31:0], pressure_q24_8 [63:32], humidity_q22_10 [80:64], zero pad
    output logic [87:0] m_tdata,
    // pressure_invalid [0]
    output logic        m_tuser
);
    cal_t cal;
    logic q_valid, q_ready;
    raw_t q_data;
    res_t res;

    thp_regs u_regs (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cal
    );

    thp_front u_front (
        .clk, .rst_n, .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
        .q_valid, .q_ready, .q_data
    );

    thp_back u_back (
        .clk, .rst_n, .cal, .q_valid, .q_ready, .q_data,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(res)
    );

    assign m_tdata = {7'd0, res.humidity_q22_10, res.pressure_q24_8, res.temp_centi};
    assign m_tuser = res.pressure_invalid;
endmodule

@@ hw/rtl/thp_front.sv @@
`timescale 1ns / 1ps
// Input queue: accepts raw readings and hands them to the compute part.
module thp_front
    import thp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  raw_t in_data,
    output logic q_valid,
    input  logic q_ready,
    output raw_t q_data
);
    localparam int unsigned AW = $clog2(QDEPTH);
    raw_t          mem_reg [QDEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          wr, rd;

    assign in_ready = (cnt_reg != (AW+1)'(QDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = mem_reg[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = q_valid && q_ready;

    // Storage.
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= in_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= wp_reg + AW'(1);
            if (rd) rp_reg <= rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule

@@ hw/rtl/thp_back.sv @@
`timescale 1ns / 1ps
// Compensation pipeline. One reading enters a cycle; the whole pipe stalls
// when the output register is full and not taken. The division is a
// 64-stage restoring pipeline, one quotient bit per stage.
module thp_back
    import thp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cal_t cal,
    input  logic q_valid,
    output logic q_ready,
    input  raw_t q_data,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_data
);
    localparam int unsigned NDIV = 64;
    logic adv;
    assign adv = !out_valid || out_ready;
    assign q_ready = adv;

    // Calibration fields.
    logic signed [31:0] t1, t2, t3;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [31:0] h1, h2, h3, h4, h5, h6;
    assign t1 = {16'd0, cal.cal_temp[15:0]};
    assign t2 = {{16{cal.cal_temp[31]}}, cal.cal_temp[31:16]};
    assign t3 = {{16{cal.cal_temp[47]}}, cal.cal_temp[47:32]};
    assign p1 = {48'd0, cal.cal_press_a[15:0]};
    assign p2 = {{48{cal.cal_press_a[31]}}, cal.cal_press_a[31:16]};
    assign p3 = {{48{cal.cal_press_a[47]}}, cal.cal_press_a[47:32]};
    assign p4 = {{48{cal.cal_press_a[63]}}, cal.cal_press_a[63:48]};
    assign p5 = {{48{cal.cal_press_b[15]}}, cal.cal_press_b[15:0]};
    assign p6 = {{48{cal.cal_press_b[31]}}, cal.cal_press_b[31:16]};
    assign p7 = {{48{cal.cal_press_b[47]}}, cal.cal_press_b[47:32]};
    assign p8 = {{48{cal.cal_press_b[63]}}, cal.cal_press_b[63:48]};
    assign p9 = {{48{cal.cal_press_c[15]}}, cal.cal_press_c};
    assign h1 = {24'd0, cal.cal_hum[7:0]};
    assign h2 = {{16{cal.cal_hum[23]}}, cal.cal_hum[23:8]};
    assign h3 = {24'd0, cal.cal_hum[31:24]};
    assign h4 = {{20{cal.cal_hum[43]}}, cal.cal_hum[43:32]};
    assign h5 = {{20{cal.cal_hum[55]}}, cal.cal_hum[55:44]};
    assign h6 = {{24{cal.cal_hum[63]}}, cal.cal_hum[63:56]};

    // Stage A: temperature products.
    logic               a_v_reg;
    logic signed [31:0] a_v1_reg, a_dd_reg;
    logic [19:0]        a_ap_reg;
    logic [15:0]        a_ah_reg;
    logic signed [31:0] a_x1, a_d;
    assign a_x1 = {15'd0, q_data.adc_temp[19:3]} - (t1 <<< 1);
    assign a_d  = {16'd0, q_data.adc_temp[19:4]} - t1;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_v1_reg <= 32'(a_x1 * t2) >>> 11;
            a_dd_reg <= 32'(a_d * a_d) >>> 12;
            a_ap_reg <= q_data.adc_pressure;
            a_ah_reg <= q_data.adc_humidity;
        end
    end

    // Stage B: fine temperature.
    logic               b_v_reg;
    logic signed [31:0] b_tf_reg;
    logic [19:0]        b_ap_reg;
    logic [15:0]        b_ah_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_tf_reg <= a_v1_reg + (32'(a_dd_reg * t3) >>> 14);
            b_ap_reg <= a_ap_reg;
            b_ah_reg <= a_ah_reg;
        end
    end

    // Stage C: temperature output, pressure and humidity first products.
    logic               c_v_reg;
    logic signed [31:0] c_temp_reg, c_b_reg, c_c_reg, c_hx_reg;
    logic signed [63:0] c_w1_reg, c_w1sq_reg;
    logic [19:0]        c_ap_reg;
    logic signed [31:0] c_x;
    logic signed [63:0] c_w1;
    assign c_x  = b_tf_reg - 32'sd76800;
    assign c_w1 = 64'(b_tf_reg) - 64'sd128000;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_temp_reg <= (32'(b_tf_reg * 32'sd5) + 32'sd128) >>> 8;
            c_w1_reg <= c_w1;
            c_w1sq_reg <= c_w1 * c_w1;
            c_b_reg <= 32'(c_x * h6) >>> 10;
            c_c_reg <= (32'(c_x * h3) >>> 11) + 32'sd32768;
            c_hx_reg <= ({2'd0, b_ah_reg, 14'd0}) - (h4 <<< 20) - 32'(h5 * c_x)
                + 32'sd16384;
            c_ap_reg <= b_ap_reg;
        end
    end

    // Stage D: pressure partial sums, humidity e and a.
    logic               d_v_reg;
    logic signed [63:0] d_w2_reg, d_w1_reg;
    logic signed [31:0] d_e_reg, d_a_reg, d_temp_reg;
    logic [19:0]        d_ap_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_w2_reg <= c_w1sq_reg * p6 + ((c_w1_reg * p5) <<< 17) + (p4 <<< 35);
            d_w1_reg <= (64'(c_w1sq_reg * p3) >>> 8) + ((c_w1_reg * p2) <<< 12);
            d_e_reg <= (32'(c_b_reg * c_c_reg) >>> 10) + 32'sd2097152;
            d_a_reg <= c_hx_reg >>> 15;
            d_temp_reg <= c_temp_reg;
            d_ap_reg <= c_ap_reg;
        end
    end

    // Stage E: divisor, numerator, humidity f.
    logic               e_v_reg;
    logic signed [63:0] e_den_reg, e_num_reg;
    logic signed [31:0] e_f_reg, e_a_reg, e_temp_reg;
    logic signed [63:0] e_pp;
    assign e_pp = 64'sd1048576 - {44'd0, d_ap_reg};
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_den_reg <= 64'(((64'sd1 <<< 47) + d_w1_reg) * p1) >>> 33;
            e_num_reg <= 64'(((e_pp <<< 31) - d_w2_reg) * 64'sd3125);
            e_f_reg <= (32'(d_e_reg * h2) + 32'sd8192) >>> 14;
            e_a_reg <= d_a_reg;
            e_temp_reg <= d_temp_reg;
        end
    end

    // Stage F: humidity product, divider operand setup.
    logic               f_v_reg;
    logic signed [31:0] f_h_reg, f_temp_reg;
    logic [63:0]        f_mn_reg, f_md_reg;
    logic               f_neg_reg, f_inv_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_h_reg <= 32'(e_a_reg * e_f_reg);
            f_temp_reg <= e_temp_reg;
            f_mn_reg <= e_num_reg[63] ? 64'(-e_num_reg) : e_num_reg;
            f_md_reg <= e_den_reg[63] ? 64'(-e_den_reg) : e_den_reg;
            f_neg_reg <= e_num_reg[63] ^ e_den_reg[63];
            f_inv_reg <= (e_den_reg == '0);
        end
    end

    // Divider pipeline; temperature and the humidity product ride alongside.
    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] num;
        logic [63:0] den;
        logic        neg;
        logic        inv;
        logic [31:0] temp;
        logic [31:0] hum;
    } div_t;
    div_t dv_in;
    div_t dv_reg [NDIV];
    logic [NDIV-1:0] dvv_reg;

    assign dv_in = '{rem: '0, num: f_mn_reg, den: f_md_reg, neg: f_neg_reg,
        inv: f_inv_reg, temp: f_temp_reg, hum: f_h_reg};

    for (genvar k = 0; k < NDIV; k++)
    begin : g_div
        div_t src;
        logic [64:0] trial;
        logic [64:0] sh;
        if (k == 0)
        begin : g_first
            assign src = dv_in;
        end
        else
        begin : g_next
            assign src = dv_reg[k-1];
        end
        assign sh = {src.rem, src.num[63]};
        assign trial = sh - {1'b0, src.den};
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[k].den <= src.den;
                dv_reg[k].neg <= src.neg;
                dv_reg[k].inv <= src.inv;
                dv_reg[k].temp <= src.temp;
                dv_reg[k].hum <= src.hum;
                if (!trial[64])
                begin
                    dv_reg[k].rem <= trial[63:0];
                    dv_reg[k].num <= {src.num[62:0], 1'b1};
                end
                else
                begin
                    dv_reg[k].rem <= sh[63:0];
                    dv_reg[k].num <= {src.num[62:0], 1'b0};
                end
            end
        end
    end

    // Stage G: signed quotient, pressure products and humidity square.
    logic               g_v_reg;
    logic signed [63:0] g_p_reg, g_ps_reg, g_w2_reg;
    logic               g_inv_reg;
    logic [31:0]        g_temp_reg;
    logic signed [31:0] g_hum_reg, g_sq_reg;
    logic signed [63:0] g_q;
    logic signed [31:0] g_h, g_s;
    assign g_q = dv_reg[NDIV-1].neg ? 64'(-dv_reg[NDIV-1].num) : dv_reg[NDIV-1].num;
    assign g_h = $signed(dv_reg[NDIV-1].hum);
    assign g_s = g_h >>> 15;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_p_reg <= g_q;
            g_ps_reg <= g_q >>> 13;
            g_w2_reg <= 64'(p8 * g_q) >>> 19;
            g_inv_reg <= dv_reg[NDIV-1].inv;
            g_temp_reg <= dv_reg[NDIV-1].temp;
            g_hum_reg <= g_h;
            g_sq_reg <= 32'(g_s * g_s) >>> 7;
        end
    end

    // Stage H: p9*ps, with the product by ps left to stage I; humidity finish.
    logic               h_v_reg;
    logic signed [63:0] h_p_reg, h_m_reg, h_ps_reg, h_w2_reg;
    logic               h_inv_reg;
    logic [31:0]        h_temp_reg;
    logic signed [31:0] h_hum_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_p_reg <= g_p_reg;
            h_m_reg <= 64'(p9 * g_ps_reg);
            h_ps_reg <= g_ps_reg;
            h_w2_reg <= g_w2_reg;
            h_inv_reg <= g_inv_reg;
            h_temp_reg <= g_temp_reg;
            h_hum_reg <= g_hum_reg - (32'(g_sq_reg * h1) >>> 4);
        end
    end

    // Stage I: low 64 bits of (p9*ps)*ps from 32-bit partial products.
    logic               i_v_reg;
    logic signed [63:0] i_p_reg, i_w2_reg;
    logic [63:0]        i_ll_reg;
    logic [31:0]        i_cr_reg;
    logic               i_inv_reg;
    logic [31:0]        i_temp_reg;
    logic signed [31:0] i_hum_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i_p_reg <= h_p_reg;
            i_w2_reg <= h_w2_reg;
            i_ll_reg <= 64'(h_m_reg[31:0]) * 64'(h_ps_reg[31:0]);
            i_cr_reg <= 32'(h_m_reg[31:0] * h_ps_reg[63:32])
                + 32'(h_m_reg[63:32] * h_ps_reg[31:0]);
            i_inv_reg <= h_inv_reg;
            i_temp_reg <= h_temp_reg;
            i_hum_reg <= h_hum_reg;
        end
    end

    // Output register.
    logic [63:0]        o_mm;
    logic signed [63:0] o_w1, o_pres;
    logic signed [31:0] o_h;
    logic [31:0]        o_hc;
    assign o_mm = i_ll_reg + {i_cr_reg, 32'd0};
    assign o_w1 = $signed(o_mm) >>> 25;
    assign o_pres = ((i_p_reg + o_w1 + i_w2_reg) >>> 8) + (p7 <<< 4);
    assign o_h = i_hum_reg;
    assign o_hc = o_h[31] ? 32'd0 : ((o_h > 32'sd419430400) ? 32'd419430400 : o_h);
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data.temp_centi <= i_temp_reg;
            out_data.pressure_q24_8 <= i_inv_reg ? 32'd0 : o_pres[31:0];
            out_data.humidity_q22_10 <= o_hc[28:12];
            out_data.pressure_invalid <= i_inv_reg;
        end
    end

    // Valid bits along the pipe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0; b_v_reg <= 1'b0; c_v_reg <= 1'b0; d_v_reg <= 1'b0;
            e_v_reg <= 1'b0; f_v_reg <= 1'b0; g_v_reg <= 1'b0; h_v_reg <= 1'b0;
            i_v_reg <= 1'b0;
            dvv_reg <= '0;
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg <= q_valid; b_v_reg <= a_v_reg; c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg; e_v_reg <= d_v_reg; f_v_reg <= e_v_reg;
            dvv_reg <= {dvv_reg[NDIV-2:0], f_v_reg};
            g_v_reg <= dvv_reg[NDIV-1];
            h_v_reg <= g_v_reg;
            i_v_reg <= h_v_reg;
            out_valid <= i_v_reg;
        end
    end
endmodule

@@ hw/rtl/thp_regs.sv @@
`timescale 1ns / 1ps
// Calibration register file on the configuration port.
module thp_regs
    import thp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output cal_t        cal
);
    logic [2:0] idx;
    assign idx = paddr[5:3];
    assign pready = 1'b1;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_TEMP: cal.cal_temp <= pwdata[47:0];
                REG_PA:   cal.cal_press_a <= pwdata;
                REG_PB:   cal.cal_press_b <= pwdata;
                REG_PC:   cal.cal_press_c <= pwdata[15:0];
                REG_HUM:  cal.cal_hum <= pwdata;
                default:  ;
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        unique case (idx)
            REG_TEMP: prdata = {16'd0, cal.cal_temp};
            REG_PA:   prdata = cal.cal_press_a;
            REG_PB:   prdata = cal.cal_press_b;
            REG_PC:   prdata = {48'd0, cal.cal_press_c};
            REG_HUM:  prdata = cal.cal_hum;
            default:  prdata = '0;
        endcase
    end
endmodule

@@ hw/rtl/thp_checker.sv @@
`timescale 1ns / 1ps
`include "thp_sensor_compensation_assert.svh"
// Port-level checks of the compensation block.
module thp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic        m_tuser
);
    `THP_ASSERT_IMP(a_pready, clk, rst_n, 1'b1, pready)
    `THP_ASSERT_IMP(a_inv_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata[63:32] == 32'd0)
    `THP_ASSERT_IMP(a_hum_range, clk, rst_n, m_tvalid, m_tdata[80:64] <= 17'd102400)
    `THP_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind thp_sensor_compensation thp_checker u_thp_checker (
    .clk, .rst_n, .pready, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);
